>>> hw/rtl/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and codes for the 4x4 matrix vector transform
// Element type, item operation codes and the queue entry that carries one
// classified beat from the front end to the execution unit.
// ----------------------------------------------------------------------------
package mvt_pkg;

	typedef logic signed [31:0] elem_t;

	localparam logic [1:0] MODE_LOAD_MAIN = 2'd0;
	localparam logic [1:0] MODE_XFORM     = 2'd1;
	localparam logic [1:0] MODE_LOAD_SEC  = 2'd2;
	localparam logic [1:0] MODE_COMPOSE   = 2'd3;

	localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;
	localparam elem_t ELEM_MIN = 32'sh8000_0000;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;

	typedef enum logic [1:0] {
		OP_LOAD_MAIN,
		OP_XFORM,
		OP_LOAD_SEC,
		OP_COMPOSE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  index;
		elem_t       value;
		elem_t       vx;
		elem_t       vy;
		elem_t       vz;
		elem_t       vw;
	} item_t;

endpackage

>>> hw/rtl/mvt_front.sv
// ----------------------------------------------------------------------------
// mvt_front: input register and classifier
// Takes input beats, decodes the mode into an operation code and holds the
// entry until the queue has room.
// ----------------------------------------------------------------------------
module mvt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     mode,
	input  logic [3:0]     index,
	input  mvt_pkg::elem_t value,
	input  mvt_pkg::elem_t vec_x,
	input  mvt_pkg::elem_t vec_y,
	input  mvt_pkg::elem_t vec_z,
	input  mvt_pkg::elem_t vec_w,
	output logic           push_valid,
	output mvt_pkg::item_t push_item,
	input  logic           q_full
);
	import mvt_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	op_t   op_dec;
	logic  accept;
	logic  push;

	always_comb begin
		unique case (mode)
			MODE_LOAD_MAIN: op_dec = OP_LOAD_MAIN;
			MODE_XFORM:     op_dec = OP_XFORM;
			MODE_LOAD_SEC:  op_dec = OP_LOAD_SEC;
			MODE_COMPOSE:   op_dec = OP_COMPOSE;
		endcase
	end

	assign push     = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !push);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op    <= op_dec;
			item_s1.index <= index;
			item_s1.value <= value;
			item_s1.vx    <= vec_x;
			item_s1.vy    <= vec_y;
			item_s1.vz    <= vec_z;
			item_s1.vw    <= vec_w;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

>>> hw/rtl/mvt_queue.sv
// ----------------------------------------------------------------------------
// mvt_queue: short FIFO between front end and execution unit
// Four entries; lets the front keep taking beats while a compose runs.
// ----------------------------------------------------------------------------
module mvt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  mvt_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           pop_valid,
	output mvt_pkg::item_t pop_item
);
	import mvt_pkg::*;

	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   cnt_q;
	logic               wr_en;
	logic               rd_en;

	assign full      = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign wr_en     = push_valid && !full;
	assign rd_en     = pop && pop_valid;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= push_item;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (Q_PTR_W+1)'(Q_DEPTH))
		else $error("queue count above depth");

endmodule

>>> hw/rtl/mvt_back.sv
// ----------------------------------------------------------------------------
// mvt_back: matrix storage and dot product engine
// Holds both matrices, applies element loads, and runs transforms and
// composes through four multiplier lanes, one dot product per cycle.
// ----------------------------------------------------------------------------
module mvt_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  mvt_pkg::item_t q_item,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output mvt_pkg::elem_t out_x,
	output mvt_pkg::elem_t out_y,
	output mvt_pkg::elem_t out_z,
	output mvt_pkg::elem_t out_w,
	output logic           saturated
);
	import mvt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	localparam elem_t ONE = elem_t'(32'd1 << FRAC_BITS);

	state_t state_q;
	op_t    op_q;
	logic [3:0] cnt_q;

	// main_q[row][col], sec_q[col][row]: one row or one column read per cycle
	elem_t main_q [4][4];
	elem_t sec_q  [4][4];
	elem_t vec_q  [4];
	elem_t res_q  [4];
	logic  sat_q;

	elem_t opa [4];
	elem_t opb [4];
	logic [1:0] row_sel;
	logic [1:0] col_sel;
	logic       last_issue;
	logic       slot_free;

	logic               valid_s1;
	logic               last_s1;
	logic [3:0]         tag_s1;
	logic signed [63:0] prod_s1 [4];
	logic signed [63:0] term [4];

	logic               valid_s2;
	logic               last_s2;
	logic [3:0]         tag_s2;
	logic signed [64:0] pair0_s2;
	logic signed [64:0] pair1_s2;

	logic signed [65:0] total;
	logic               ovf;
	elem_t              satval;

	logic  out_valid_q;
	logic  out_sat_q;
	elem_t out_q [4];

	assign q_pop     = q_valid && (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;

	assign row_sel    = (op_q == OP_XFORM) ? cnt_q[1:0] : cnt_q[3:2];
	assign col_sel    = cnt_q[1:0];
	assign last_issue = (op_q == OP_XFORM) ? (cnt_q == 4'd3) : (cnt_q == 4'd15);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			opa[k] = main_q[row_sel][k];
			opb[k] = (op_q == OP_XFORM) ? vec_q[k] : sec_q[col_sel][k];
			term[k] = prod_s1[k] >>> FRAC_BITS;
		end
	end

	// exact sum of the four floored terms, then clamp to 32 bits
	assign total  = 66'($signed({pair0_s2[64], pair0_s2})) +
	                66'($signed({pair1_s2[64], pair1_s2}));
	assign ovf    = !((&total[65:31]) || !(|total[65:31]));
	assign satval = ovf ? (total[65] ? ELEM_MIN : ELEM_MAX) : elem_t'(total[31:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_LOAD_MAIN;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						op_q  <= q_item.op;
						cnt_q <= '0;
						if (q_item.op == OP_XFORM || q_item.op == OP_COMPOSE)
							state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_issue)
						state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (valid_s2 && last_s2)
						state_q <= (op_q == OP_XFORM) ? ST_DONE : ST_IDLE;
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					main_q[r][c] <= (r == c) ? ONE : '0;
					sec_q[r][c]  <= (r == c) ? ONE : '0;
				end
			end
		end else begin
			if (q_pop && q_item.op == OP_LOAD_MAIN)
				main_q[q_item.index[3:2]][q_item.index[1:0]] <= q_item.value;
			else if (valid_s2 && op_q == OP_COMPOSE && tag_s2[1:0] == 2'd3) begin
				// row finished: later dot products do not read this row again
				for (int k = 0; k < 3; k++)
					main_q[tag_s2[3:2]][k] <= res_q[k];
				main_q[tag_s2[3:2]][3] <= satval;
			end
			if (q_pop && q_item.op == OP_LOAD_SEC)
				sec_q[q_item.index[1:0]][q_item.index[3:2]] <= q_item.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= (state_q == ST_ISSUE);
			valid_s2    <= valid_s1;
			out_valid_q <= ((state_q == ST_DONE) && slot_free) || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.op == OP_XFORM) begin
			vec_q[0] <= q_item.vx;
			vec_q[1] <= q_item.vy;
			vec_q[2] <= q_item.vz;
			vec_q[3] <= q_item.vw;
			sat_q    <= 1'b0;
		end else if (valid_s2 && op_q == OP_XFORM) begin
			sat_q <= sat_q || ovf;
		end
		for (int k = 0; k < 4; k++)
			prod_s1[k] <= opa[k] * opb[k];
		tag_s1   <= cnt_q;
		last_s1  <= last_issue;
		pair0_s2 <= 65'($signed({term[0][63], term[0]})) + 65'($signed({term[1][63], term[1]}));
		pair1_s2 <= 65'($signed({term[2][63], term[2]})) + 65'($signed({term[3][63], term[3]}));
		tag_s2   <= tag_s1;
		last_s2  <= last_s1;
		if (valid_s2)
			res_q[tag_s2[1:0]] <= satval;
		if ((state_q == ST_DONE) && slot_free) begin
			for (int k = 0; k < 4; k++)
				out_q[k] <= res_q[k];
			out_sat_q <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_q[0];
	assign out_y     = out_q[1];
	assign out_z     = out_q[2];
	assign out_w     = out_q[3];
	assign saturated = out_sat_q;

	a_s2_after_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1))
		else $error("stage 2 valid without stage 1");

	a_done_xform: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (op_q == OP_XFORM))
		else $error("result pending for a non-transform item");

	a_last_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2) |-> (state_q == ST_WAIT))
		else $error("last dot product outside drain state");

endmodule

>>> hw/rtl/matrix4_vector_transform.sv
// ----------------------------------------------------------------------------
// matrix4_vector_transform: 4x4 Q16.16 matrix times 4-vector unit
// Input channel in_valid/in_stall carries one beat per item: mode, index,
// value and the vector. Modes 0 and 2 load one element of the main or the
// second matrix, mode 3 replaces main with main times second, mode 1
// transforms the vector and returns one beat on out_valid/out_stall.
// A front register classifies each beat into a four-entry queue; the
// execution unit drains it one item at a time. A load is written when it
// is popped; a transform runs 4 dot products through the 4 multiplier lanes,
// a 2-stage add and the result hand-off, a compose 16 dot products plus
// drain. The front keeps taking beats while the unit works until the queue
// fills. A held output beat stalls only the next transform at its hand-off;
// loads and composes keep running. Reset sets both matrices to identity and
// empties the queue and the pipeline; the block takes beats right away.
// ----------------------------------------------------------------------------
module matrix4_vector_transform #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     mode,
	input  logic [3:0]     index,
	input  mvt_pkg::elem_t value,
	input  mvt_pkg::elem_t vec_x,
	input  mvt_pkg::elem_t vec_y,
	input  mvt_pkg::elem_t vec_z,
	input  mvt_pkg::elem_t vec_w,
	output logic           out_valid,
	input  logic           out_stall,
	output mvt_pkg::elem_t out_x,
	output mvt_pkg::elem_t out_y,
	output mvt_pkg::elem_t out_z,
	output mvt_pkg::elem_t out_w,
	output logic           saturated
);
	import mvt_pkg::*;

	logic  push_valid;
	item_t push_item;
	logic  q_full;
	logic  q_pop;
	logic  q_valid;
	item_t q_item;

	mvt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.index      (index),
		.value      (value),
		.vec_x      (vec_x),
		.vec_y      (vec_y),
		.vec_z      (vec_z),
		.vec_w      (vec_w),
		.push_valid (push_valid),
		.push_item  (push_item),
		.q_full     (q_full)
	);

	mvt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_item   (q_item)
	);

	mvt_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_w     (out_w),
		.saturated (saturated)
	);

endmodule

>>> bench/matrix4_vector_transform_test.sv
// ----------------------------------------------------------------------------
// matrix4_vector_transform_test: self-checking bench for the 4x4 transform unit
// Tracks both matrices alongside the block, predicts every transform beat
// in Q16.16 with floor-rounded products and saturating sums, and compares
// the beats in order. Directed corner items come first, then random items
// under random idling and stalls on both sides, a long output hold-off and
// a full drain.
// ----------------------------------------------------------------------------
module matrix4_vector_transform_test;

	import mvt_pkg::*;

	localparam int    FRAC_BITS    = 16;
	localparam int    CYCLE_LIMIT  = 1_000_000;
	localparam int    RANDOM_ITEMS = 1600;
	localparam int    HOLD_CYCLES  = 300;
	localparam int    DRAIN_CYCLES = 50;
	localparam elem_t ONE          = 32'sh0001_0000;
	localparam elem_t HALF         = 32'sh0000_8000;

	typedef struct {
		elem_t x;
		elem_t y;
		elem_t z;
		elem_t w;
		logic  sat;
	} xform_beat_t;

	class transform_ledger;
		elem_t       main_m[16];
		elem_t       sec_m[16];
		xform_beat_t owed[$];
		int          errors;

		function new();
			for (int i = 0; i < 16; i++) begin
				main_m[i] = (i % 5 == 0) ? ONE : '0;
				sec_m[i]  = (i % 5 == 0) ? ONE : '0;
			end
			errors = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		// exact products, floored, summed in 64 bits, then clamped
		function elem_t sat_dot(elem_t a[4], elem_t b[4], inout bit clamped);
			longint acc;
			acc = 0;
			for (int k = 0; k < 4; k++)
				acc += (longint'(a[k]) * longint'(b[k])) >>> FRAC_BITS;
			if (acc > longint'(ELEM_MAX)) begin
				clamped = 1'b1;
				return ELEM_MAX;
			end
			if (acc < longint'(ELEM_MIN)) begin
				clamped = 1'b1;
				return ELEM_MIN;
			end
			return elem_t'(acc[31:0]);
		endfunction

		function void note_item(logic [1:0] md, logic [3:0] idx, elem_t val,
				elem_t vx, elem_t vy, elem_t vz, elem_t vw);
			elem_t       nxt[16];
			elem_t       row[4];
			elem_t       col[4];
			elem_t       vec[4];
			elem_t       comp[4];
			xform_beat_t beat;
			bit          junk;
			bit          clamped;
			case (md)
				MODE_LOAD_MAIN: main_m[idx] = val;
				MODE_LOAD_SEC:  sec_m[idx] = val;
				MODE_COMPOSE: begin
					// clamping inside compose is silent
					for (int ri = 0; ri < 4; ri++) begin
						for (int ci = 0; ci < 4; ci++) begin
							for (int k = 0; k < 4; k++) begin
								row[k] = main_m[ri * 4 + k];
								col[k] = sec_m[k * 4 + ci];
							end
							junk = 1'b0;
							nxt[ri * 4 + ci] = sat_dot(row, col, junk);
						end
					end
					main_m = nxt;
				end
				default: begin
					vec[0] = vx;
					vec[1] = vy;
					vec[2] = vz;
					vec[3] = vw;
					clamped = 1'b0;
					for (int ri = 0; ri < 4; ri++) begin
						for (int k = 0; k < 4; k++)
							row[k] = main_m[ri * 4 + k];
						comp[ri] = sat_dot(row, vec, clamped);
					end
					beat.x = comp[0];
					beat.y = comp[1];
					beat.z = comp[2];
					beat.w = comp[3];
					beat.sat = clamped;
					owed.push_back(beat);
				end
			endcase
		endfunction

		function void check_vector(xform_beat_t got);
			xform_beat_t want;
			if (owed.size() == 0) begin
				flag($sformatf("unexpected result beat: x=%0d y=%0d z=%0d w=%0d sat=%0b",
					got.x, got.y, got.z, got.w, got.sat));
				return;
			end
			want = owed.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
					got.w !== want.w || got.sat !== want.sat)
				flag($sformatf({"result mismatch: expected x=%0d y=%0d z=%0d w=%0d sat=%0b,",
					" got x=%0d y=%0d z=%0d w=%0d sat=%0b"},
					want.x, want.y, want.z, want.w, want.sat,
					got.x, got.y, got.z, got.w, got.sat));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = MODE_LOAD_MAIN;
	logic [3:0]  index = '0;
	elem_t       value = '0;
	elem_t       vec_x = '0;
	elem_t       vec_y = '0;
	elem_t       vec_z = '0;
	elem_t       vec_w = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	elem_t       out_x;
	elem_t       out_y;
	elem_t       out_z;
	elem_t       out_w;
	logic        saturated;

	transform_ledger ledger;
	xform_beat_t     seen_beat;
	bit              hold_req = 1'b0;
	bit              quiet = 1'b0;
	int              cycles = 0;

	matrix4_vector_transform #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.index     (index),
		.value     (value),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.vec_w     (vec_w),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_w     (out_w),
		.saturated (saturated)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("matrix4_vector_transform verification failed");
			$finish;
		end
	end

	// input beat is noted before the output beat of the same edge is checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				ledger.note_item(mode, index, value, vec_x, vec_y, vec_z, vec_w);
			if (out_valid && !out_stall) begin
				seen_beat.x = out_x;
				seen_beat.y = out_y;
				seen_beat.z = out_z;
				seen_beat.w = out_w;
				seen_beat.sat = saturated;
				ledger.check_vector(seen_beat);
			end
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(0, 3);
	endfunction

	// mostly values within +-4.0 so that sums stay in range, some extremes
	function automatic elem_t rand_elem();
		case ($urandom_range(0, 19))
			0:       return ELEM_MAX;
			1:       return ELEM_MIN;
			2, 3:    return elem_t'($urandom);
			default: return elem_t'(int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
		endcase
	endfunction

	task automatic send_item(logic [1:0] md, logic [3:0] idx, elem_t val,
			elem_t vx, elem_t vy, elem_t vz, elem_t vw);
		in_valid <= 1'b1;
		mode     <= md;
		index    <= idx;
		value    <= val;
		vec_x    <= vx;
		vec_y    <= vy;
		vec_z    <= vz;
		vec_w    <= vw;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle_sender(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// one extra edge so the last accepted beat is already in the ledger
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		bit lvl;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				lvl = ($urandom_range(0, 2) == 0);
				out_stall <= lvl;
				repeat (lvl ? pick_gap() + 1 : $urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	initial begin
		int         pick;
		logic [1:0] md;
		ledger = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state of both matrices; index and value ignored on a transform
		send_item(MODE_XFORM, 4'd15, ELEM_MAX, ELEM_MAX, ELEM_MIN, 32'sd1, -32'sd1);
		send_item(MODE_COMPOSE, 4'd0, ELEM_MIN, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
		send_item(MODE_XFORM, 4'd0, '0, 32'sh0003_0000, -32'sd2, ONE, HALF);
		// positive overflow on row zero
		send_item(MODE_LOAD_MAIN, 4'd0, ELEM_MAX, ELEM_MIN, '0, '0, '0);
		send_item(MODE_LOAD_MAIN, 4'd1, ELEM_MAX, '0, '0, '0, '0);
		send_item(MODE_XFORM, 4'd7, '0, ELEM_MAX, ELEM_MAX, '0, '0);
		// overflow both ways on row one, most negative and most positive products
		send_item(MODE_LOAD_MAIN, 4'd4, ELEM_MIN, '0, '0, '0, '0);
		send_item(MODE_LOAD_MAIN, 4'd5, ELEM_MIN, '0, '0, '0, '0);
		send_item(MODE_XFORM, 4'd0, '0, ELEM_MAX, ELEM_MAX, ELEM_MIN, ELEM_MIN);
		send_item(MODE_XFORM, 4'd0, '0, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
		send_item(MODE_XFORM, 4'd0, '0, '0, '0, '0, '0);
		// floor rounding of negative products and a saturating compose
		send_item(MODE_LOAD_SEC, 4'd15, -32'sd1, ELEM_MAX, '0, '0, '0);
		send_item(MODE_LOAD_SEC, 4'd10, HALF, '0, '0, '0, '0);
		send_item(MODE_LOAD_SEC, 4'd3, ELEM_MIN, '0, '0, '0, '0);
		send_item(MODE_COMPOSE, 4'd0, '0, '0, '0, '0, '0);
		send_item(MODE_XFORM, 4'd0, '0, 32'sd1, -32'sd1, -32'sd1, -ONE);
		send_item(MODE_LOAD_MAIN, 4'd15, '0, '0, '0, '0, '0);
		send_item(MODE_LOAD_MAIN, 4'd2, -32'sd1, '0, '0, '0, '0);
		send_item(MODE_XFORM, 4'd0, '0, 32'sd1, 32'sd2, 32'sd3, 32'sd4);
		send_item(MODE_COMPOSE, 4'd0, '0, '0, '0, '0, '0);
		send_item(MODE_XFORM, 4'd0, '0, ONE, -ONE, HALF, ELEM_MAX);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 400) begin
				quiet = 1'b1;
				hold_req = 1'b1;
			end
			if (i == 700)
				quiet = 1'b0;
			if (i == 1000)
				wait_drained();
			if (i == 1300)
				hold_req = 1'b1;
			pick = $urandom_range(0, 99);
			md = (pick < 60) ? MODE_XFORM :
				(pick < 78) ? MODE_LOAD_MAIN :
				(pick < 96) ? MODE_LOAD_SEC : MODE_COMPOSE;
			send_item(md, 4'($urandom_range(0, 15)), rand_elem(),
				rand_elem(), rand_elem(), rand_elem(), rand_elem());
			if (!quiet && $urandom_range(0, 3) == 0)
				idle_sender(pick_gap());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("matrix4_vector_transform verification clean");
		else
			$display("matrix4_vector_transform verification failed");
		$finish;
	end

endmodule
